/* rtl/core/srx_pkg.sv */
// Package for the serial frame receiver: shared constants, phase codes and the
// result item type. It has no dependencies.
package srx_pkg;

  localparam int unsigned MaxPayloadDef = 1024;
  localparam int unsigned LenW          = 11;
  localparam int unsigned ResDepth      = 4;

  localparam logic [7:0] FlagReset  = 8'h5c;
  localparam logic [7:0] AddrReset  = 8'h01;
  localparam logic [7:0] CtrlDiscA  = 8'h0a;
  localparam logic [7:0] CtrlDiscB  = 8'h06;
  localparam logic [7:0] AckSeqOne  = 8'h11;
  localparam logic [7:0] AckSeqZero = 8'h01;

  localparam logic RegFlag = 1'b0;
  localparam logic RegAddr = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_DISC = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    FR_START = 6'b000001,
    FR_FLAG  = 6'b000010,
    FR_ADDR  = 6'b000100,
    FR_CTRL  = 6'b001000,
    FR_DATA  = 6'b010000,
    FR_OVER  = 6'b100000
  } frame_e;

  typedef enum logic [5:0] {
    DS_START = 6'b000001,
    DS_FLAG  = 6'b000010,
    DS_ADDR  = 6'b000100,
    DS_CTLA  = 6'b001000,
    DS_CTLB  = 6'b010000,
    DS_CHK   = 6'b100000
  } disc_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [7:0]        ack;
    logic [LenW-1:0]   len;
    logic              last;
  } result_t;

endpackage

/* rtl/core/srx_res_fifo.sv */
// Result queue of the serial frame receiver: takes up to two result items per
// cycle and hands them out one at a time. Depends on srx_pkg.
module srx_res_fifo #(
  parameter int unsigned Depth = srx_pkg::ResDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_n_i,
  input  srx_pkg::result_t push0_i,
  input  srx_pkg::result_t push1_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            stall_i,
  output srx_pkg::result_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  srx_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_nx;
  logic [CntW-1:0]  count_q, count_d;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign valid_o  = (count_q != '0);
  assign head_o   = mem_q[rd_ptr_q];
  assign pop      = valid_o && !stall_i;
  // Two free entries are needed, since one item may cause two results.
  assign room_o   = (count_q <= CntW'(Depth - 2));
  assign wr_ptr_nx = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    case (push_n_i)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_n_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/core/serial_frame_receiver.sv */
// Serial frame receiver: recognises information frames and disconnect frames
// in a byte stream, one byte per cycle. Depends on srx_pkg and srx_res_fifo.
// Results that a byte gives rise to are pushed into the result queue and offered in order.
// Throughput: one byte per cycle; input stalls only while the four-entry
// result queue has fewer than two free entries.
// Reset: both frame machines return to start, the sequence bit clears and the
// registers take their reset values; no clearing pass is needed.
module serial_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = srx_pkg::MaxPayloadDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [7:0]               cfg_wdata_i,
  input  logic                     rx_valid_i,
  output logic                     rx_stall_o,
  input  logic [7:0]               rx_byte_i,
  output logic                     res_valid_o,
  input  logic                     res_stall_i,
  output logic [1:0]               result_kind_o,
  output logic [7:0]               data_byte_o,
  output logic [7:0]               ack_control_o,
  output logic [srx_pkg::LenW-1:0] payload_length_o,
  output logic                     last_o
);

  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned LenW = srx_pkg::LenW;

  logic [7:0]       flag_q, addr_q;
  srx_pkg::frame_e  frame_q, frame_d;
  srx_pkg::disc_e   disc_q, disc_d;
  logic             seq_q, seq_d;
  logic [7:0]       held_q, held_d;
  logic             held_vld_q, held_vld_d;
  logic [7:0]       xor_q, xor_d;
  logic [CntW-1:0]  count_q, count_d;

  logic             accept, room, is_flag, disc_hit, fr_emit;
  logic [7:0]       seq_byte;
  logic [CntW+LenW-1:0] count_ext;
  srx_pkg::result_t fr_res, disc_res, push0, push1, head;
  logic [1:0]       push_n;

  assign rx_stall_o = !room;
  assign accept     = rx_valid_i && room;
  assign is_flag    = (rx_byte_i == flag_q);
  assign seq_byte   = {7'd0, seq_q};
  assign count_ext  = {LenW'(0), count_q};

  always_comb begin
    disc_d   = disc_q;
    disc_hit = 1'b0;
    case (disc_q)
      srx_pkg::DS_FLAG: begin
        if (rx_byte_i == addr_q) disc_d = srx_pkg::DS_ADDR;
        else disc_d = is_flag ? srx_pkg::DS_FLAG : srx_pkg::DS_START;
      end
      srx_pkg::DS_ADDR: begin
        if (rx_byte_i == srx_pkg::CtrlDiscA) disc_d = srx_pkg::DS_CTLA;
        else if (rx_byte_i == srx_pkg::CtrlDiscB) disc_d = srx_pkg::DS_CTLB;
        else disc_d = is_flag ? srx_pkg::DS_FLAG : srx_pkg::DS_START;
      end
      srx_pkg::DS_CTLA: begin
        if (rx_byte_i == (addr_q ^ srx_pkg::CtrlDiscA)) disc_d = srx_pkg::DS_CHK;
        else disc_d = is_flag ? srx_pkg::DS_FLAG : srx_pkg::DS_START;
      end
      srx_pkg::DS_CTLB: begin
        if (rx_byte_i == (addr_q ^ srx_pkg::CtrlDiscB)) disc_d = srx_pkg::DS_CHK;
        else disc_d = is_flag ? srx_pkg::DS_FLAG : srx_pkg::DS_START;
      end
      srx_pkg::DS_CHK: begin
        if (is_flag) begin
          disc_hit = 1'b1;
          disc_d   = srx_pkg::DS_START;
        end
      end
      default: begin
        disc_d = is_flag ? srx_pkg::DS_FLAG : srx_pkg::DS_START;
      end
    endcase

    frame_d    = frame_q;
    seq_d      = seq_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    xor_d      = xor_q;
    count_d    = count_q;
    fr_emit    = 1'b0;
    fr_res     = '{kind: srx_pkg::KIND_DATA, data: 8'd0, ack: 8'd0, len: '0, last: 1'b1};
    case (frame_q)
      srx_pkg::FR_FLAG: begin
        if (rx_byte_i == addr_q) frame_d = srx_pkg::FR_ADDR;
        else frame_d = is_flag ? srx_pkg::FR_FLAG : srx_pkg::FR_START;
      end
      srx_pkg::FR_ADDR: begin
        if (rx_byte_i == seq_byte) frame_d = srx_pkg::FR_CTRL;
        else frame_d = is_flag ? srx_pkg::FR_FLAG : srx_pkg::FR_START;
      end
      srx_pkg::FR_CTRL: begin
        if (rx_byte_i == (addr_q ^ seq_byte)) begin
          frame_d    = srx_pkg::FR_DATA;
          held_vld_d = 1'b0;
          xor_d      = 8'd0;
          count_d    = '0;
        end else begin
          frame_d = is_flag ? srx_pkg::FR_FLAG : srx_pkg::FR_START;
        end
      end
      srx_pkg::FR_DATA: begin
        if (is_flag) begin
          seq_d   = !seq_q;
          fr_emit = 1'b1;
          if (held_vld_q && (held_q == xor_q)) begin
            fr_res.kind = srx_pkg::KIND_GOOD;
            fr_res.ack  = seq_q ? srx_pkg::AckSeqZero : srx_pkg::AckSeqOne;
            fr_res.len  = count_ext[LenW-1:0];
            // A good frame also restarts the disconnect detector.
            disc_d      = srx_pkg::DS_START;
          end else begin
            fr_res.kind = srx_pkg::KIND_BAD;
          end
          frame_d    = srx_pkg::FR_START;
          held_vld_d = 1'b0;
          xor_d      = 8'd0;
          count_d    = '0;
        end else if (held_vld_q && (count_q >= CntW'(MAX_PAYLOAD))) begin
          frame_d = srx_pkg::FR_OVER;
        end else begin
          // The previous byte goes out now; the newest is held back in case
          // it turns out to be the check byte.
          if (held_vld_q) begin
            fr_emit     = 1'b1;
            fr_res.data = held_q;
            xor_d       = xor_q ^ held_q;
            count_d     = count_q + CntW'(1);
          end
          held_d     = rx_byte_i;
          held_vld_d = 1'b1;
        end
      end
      srx_pkg::FR_OVER: begin
        if (is_flag) begin
          seq_d       = !seq_q;
          fr_emit     = 1'b1;
          fr_res.kind = srx_pkg::KIND_BAD;
          frame_d     = srx_pkg::FR_START;
          held_vld_d  = 1'b0;
          xor_d       = 8'd0;
          count_d     = '0;
        end
      end
      default: begin
        frame_d = is_flag ? srx_pkg::FR_FLAG : srx_pkg::FR_START;
      end
    endcase

    disc_res = '{kind: srx_pkg::KIND_DISC, data: 8'd0, ack: 8'd0, len: '0,
                 last: !fr_emit};
    push_n   = 2'd0;
    push0    = fr_res;
    push1    = fr_res;
    if (accept) begin
      if (disc_hit) begin
        push0  = disc_res;
        push_n = fr_emit ? 2'd2 : 2'd1;
      end else if (fr_emit) begin
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= srx_pkg::FlagReset;
      addr_q     <= srx_pkg::AddrReset;
      frame_q    <= srx_pkg::FR_START;
      disc_q     <= srx_pkg::DS_START;
      seq_q      <= 1'b0;
      held_vld_q <= 1'b0;
      xor_q      <= 8'd0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          srx_pkg::RegFlag: flag_q <= cfg_wdata_i;
          srx_pkg::RegAddr: addr_q <= cfg_wdata_i;
          default:          flag_q <= flag_q;
        endcase
      end
      if (accept) begin
        frame_q    <= frame_d;
        disc_q     <= disc_d;
        seq_q      <= seq_d;
        held_vld_q <= held_vld_d;
        xor_q      <= xor_d;
        count_q    <= count_d;
      end
    end
  end

  srx_res_fifo #(
    .Depth(srx_pkg::ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_n_i(push_n),
    .push0_i (push0),
    .push1_i (push1),
    .room_o  (room),
    .valid_o (res_valid_o),
    .stall_i (res_stall_i),
    .head_o  (head)
  );

  assign result_kind_o    = head.kind;
  assign data_byte_o      = head.data;
  assign ack_control_o    = head.ack;
  assign payload_length_o = head.len;
  assign last_o           = head.last;

endmodule
